@@ rtl/core/synapse_normalized_gradient_update_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the synapse normalized gradient update block
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SYNAPSE_NORMALIZED_GRADIENT_UPDATE_DEFINES_SVH
`define SYNAPSE_NORMALIZED_GRADIENT_UPDATE_DEFINES_SVH

// same-cycle implication, off during reset
`define SNGU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sngu assertion failed");

// next-cycle implication, off during reset
`define SNGU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sngu assertion failed");

// checked at every edge, reset included
`define SNGU_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) (expr)) \
		else $error("sngu assertion failed");

`endif

@@ rtl/core/sngu_pkg.sv @@
// ----------------------------------------------------------------------------
// sngu_pkg
// Types, widths, register indexes and reset values of the gradient update.
// ----------------------------------------------------------------------------
package sngu_pkg;

	localparam int WORD_W     = 32;
	localparam int HALF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int MODE_W     = 3;
	localparam int SQRT_IN_W  = 48;
	localparam int STEP_W     = 35;
	localparam int DIV2_SHIFT = 8;

	localparam int MODE_UPDATE = 0;
	localparam int MODE_NORM   = 1;
	localparam int MODE_DECAY  = 2;

	localparam logic [STEP_W-1:0] STEP_LIMIT = {1'b1, {(STEP_W-1){1'b0}}};

	localparam logic [WORD_W-1:0] RST_LEARNING_RATE  = 32'd0;
	localparam logic [HALF_W-1:0] RST_PEAK_DECAY     = 16'd65426;
	localparam logic [HALF_W-1:0] RST_UPDATE_PERIOD  = 16'd5000;
	localparam logic [WORD_W-1:0] RST_MIN_WEIGHT     = 32'd0;
	localparam logic [WORD_W-1:0] RST_MAX_WEIGHT     = 32'd16777216;
	localparam logic [WORD_W-1:0] RST_DECAY_STRENGTH = 32'd0;
	localparam logic [MODE_W-1:0] RST_MODE_BITS      = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE  = 3'd0,
		REG_PEAK_DECAY     = 3'd1,
		REG_UPDATE_PERIOD  = 3'd2,
		REG_MIN_WEIGHT     = 3'd3,
		REG_MAX_WEIGHT     = 3'd4,
		REG_DECAY_STRENGTH = 3'd5,
		REG_MODE_BITS      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0]        learning_rate;
		logic [HALF_W-1:0]        peak_decay;
		logic [HALF_W-1:0]        update_period;
		logic signed [WORD_W-1:0] min_weight;
		logic signed [WORD_W-1:0] max_weight;
		logic [WORD_W-1:0]        decay_strength;
		logic [MODE_W-1:0]        mode_bits;
	} cfg_t;

endpackage

@@ rtl/core/sngu_cfg.sv @@
// ----------------------------------------------------------------------------
// sngu_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module sngu_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sngu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sngu_pkg::WORD_W-1:0]     cfg_data,
	output sngu_pkg::cfg_t                  cfg
);
	import sngu_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learning_rate  <= RST_LEARNING_RATE;
			cfg_q.peak_decay     <= RST_PEAK_DECAY;
			cfg_q.update_period  <= RST_UPDATE_PERIOD;
			cfg_q.min_weight     <= RST_MIN_WEIGHT;
			cfg_q.max_weight     <= RST_MAX_WEIGHT;
			cfg_q.decay_strength <= RST_DECAY_STRENGTH;
			cfg_q.mode_bits      <= RST_MODE_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LEARNING_RATE:  cfg_q.learning_rate  <= cfg_data;
				REG_PEAK_DECAY:     cfg_q.peak_decay     <= cfg_data[HALF_W-1:0];
				REG_UPDATE_PERIOD:  cfg_q.update_period  <= cfg_data[HALF_W-1:0];
				REG_MIN_WEIGHT:     cfg_q.min_weight     <= cfg_data;
				REG_MAX_WEIGHT:     cfg_q.max_weight     <= cfg_data;
				REG_DECAY_STRENGTH: cfg_q.decay_strength <= cfg_data;
				REG_MODE_BITS:      cfg_q.mode_bits      <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/sngu_div.sv @@
// ----------------------------------------------------------------------------
// sngu_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module sngu_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] rem0,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] div,
	input  logic [PW-1:0] pay,
	output logic          out_vld,
	output logic [NW-1:0] quot,
	output logic [PW-1:0] out_pay
);

	logic          vld_s [0:NW];
	logic [DW-1:0] rem_s [0:NW];
	logic [NW-1:0] num_s [0:NW];
	logic [DW-1:0] div_s [0:NW];
	logic [PW-1:0] pay_s [0:NW];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = rem0;
	assign num_s[0] = num;
	assign div_s[0] = div;
	assign pay_s[0] = pay;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign ge    = trial >= {1'b0, div_s[k]};
		assign diff  = trial - {1'b0, div_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_s[k+1] <= {num_s[k][NW-2:0], ge};
				div_s[k+1] <= div_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_vld = vld_s[NW];
	assign quot    = num_s[NW];
	assign out_pay = pay_s[NW];

endmodule

@@ rtl/core/sngu_sqrt.sv @@
// ----------------------------------------------------------------------------
// sngu_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sngu_sqrt #(
	parameter int XW = 48,
	parameter int PW = 1,
	localparam int RW = XW / 2,
	localparam int MW = RW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [XW-1:0] x,
	input  logic [PW-1:0] pay,
	output logic          out_vld,
	output logic [RW-1:0] root,
	output logic [PW-1:0] out_pay
);

	logic          vld_s  [0:RW];
	logic [MW-1:0] rem_s  [0:RW];
	logic [RW-1:0] root_s [0:RW];
	logic [XW-1:0] x_s    [0:RW];
	logic [PW-1:0] pay_s  [0:RW];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = x;
	assign pay_s[0]  = pay;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [MW+1:0] cur;
		logic [MW+1:0] trial;
		logic [MW+1:0] diff;
		logic          ge;

		assign cur   = {rem_s[k], x_s[k][XW-1:XW-2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[MW-1:0] : cur[MW-1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				x_s[k+1]    <= {x_s[k][XW-3:0], 2'b00};
				pay_s[k+1]  <= pay_s[k];
			end
		end
	end

	assign out_vld = vld_s[RW];
	assign root    = root_s[RW];
	assign out_pay = pay_s[RW];

endmodule

@@ rtl/core/synapse_normalized_gradient_update.sv @@
// ----------------------------------------------------------------------------
// synapse_normalized_gradient_update
// Normalized gradient weight update with peak tracking, decay and clipping.
// ----------------------------------------------------------------------------
// Takes one synapse record per cycle and returns its updated weight and
// squared-gradient peak in input order. The result passes through a chain
// of bit-per-stage units: a 32-stage gradient divider, two multiply stages,
// a 24-stage square root, a 35-stage step divider and the output register.
// Throughput is one item per clock; a stalled result freezes the whole
// pipeline until it is taken. The user must write the configuration
// registers only while no item is in flight; the block does not enforce this.
module synapse_normalized_gradient_update (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [sngu_pkg::WORD_W-1:0] weight_in,
	input  logic signed [sngu_pkg::WORD_W-1:0] eligibility_sum,
	input  logic [sngu_pkg::WORD_W-1:0]        peak_in,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [sngu_pkg::WORD_W-1:0] weight_out,
	output logic [sngu_pkg::WORD_W-1:0]        peak_out,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sngu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sngu_pkg::WORD_W-1:0]        cfg_data
);
	import sngu_pkg::*;

	typedef struct packed {
		logic signed [WORD_W-1:0] w;
		logic                     gneg;
		logic [WORD_W-1:0]        peak;
	} grad_pay_t;

	typedef struct packed {
		logic [2*WORD_W-1:0]    gl;
		logic signed [WORD_W:0] wd;
		logic                   gneg;
		logic [WORD_W-1:0]      peak;
	} root_pay_t;

	typedef struct packed {
		logic signed [WORD_W:0] wd;
		logic                   gneg;
		logic [WORD_W-1:0]      peak;
		logic                   ovf;
		logic                   zero;
		logic [STEP_W-1:0]      plain;
	} step_pay_t;

	localparam int RT_W = SQRT_IN_W / 2;
	localparam int SUM_W = STEP_W + 1;

	cfg_t cfg;
	logic en;
	logic upd, norm, dec;

	assign en         = !result_valid || result_ready;
	assign item_ready = en;
	assign upd        = cfg.mode_bits[MODE_UPDATE];
	assign norm       = cfg.mode_bits[MODE_NORM];
	assign dec        = cfg.mode_bits[MODE_DECAY];

	sngu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// gradient divide
	logic              gneg0;
	logic [WORD_W-1:0] smag0;
	logic [HALF_W-1:0] period0;
	grad_pay_t         gp_in, gp_out;
	logic              d1_vld;
	logic [WORD_W-1:0] gmag;

	assign gneg0   = eligibility_sum[WORD_W-1];
	assign smag0   = gneg0 ? (~eligibility_sum + 32'd1) : eligibility_sum;
	assign period0 = (cfg.update_period == '0) ? 16'd1 : cfg.update_period;
	assign gp_in   = '{w: weight_in, gneg: gneg0, peak: peak_in};

	sngu_div #(.NW(WORD_W), .DW(HALF_W), .PW($bits(grad_pay_t))) u_div_grad (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (item_valid),
		.rem0    ('0),
		.num     (smag0),
		.div     (period0),
		.pay     (gp_in),
		.out_vld (d1_vld),
		.quot    (gmag),
		.out_pay (gp_out)
	);

	// products
	logic [WORD_W-1:0]   wmag;
	logic [47:0]         dp_prod;
	logic [2*WORD_W-1:0] dw_prod;

	logic                     vld_s1;
	logic [2*WORD_W-1:0]      g2_s1;
	logic [WORD_W-1:0]        dp_s1;
	logic [2*WORD_W-1:0]      gl_s1;
	logic [WORD_W-1:0]        dprod_s1;
	logic signed [WORD_W-1:0] w_s1;
	logic                     gneg_s1;
	logic [WORD_W-1:0]        peak_s1;

	assign wmag    = gp_out.w[WORD_W-1] ? (~gp_out.w + 32'd1) : gp_out.w;
	assign dp_prod = 48'(cfg.peak_decay) * 48'(gp_out.peak);
	assign dw_prod = 64'(wmag) * 64'(cfg.decay_strength);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g2_s1    <= 64'(gmag) * 64'(gmag);
			dp_s1    <= dp_prod[47:16];
			gl_s1    <= 64'(gmag) * 64'(cfg.learning_rate);
			dprod_s1 <= dw_prod[63:32];
			w_s1     <= gp_out.w;
			gneg_s1  <= gp_out.gneg;
			peak_s1  <= gp_out.peak;
		end
	end

	// new peak, decay amount
	logic [47:0]         g2_sh;
	logic [WORD_W-1:0]   g2_sat;
	logic [WORD_W-1:0]   peak_new;
	logic [2*WORD_W-1:0] dm_prod;

	logic                     vld_s2;
	logic [WORD_W-1:0]        peak_s2;
	logic [WORD_W-1:0]        dm_s2;
	logic [2*WORD_W-1:0]      gl_s2;
	logic signed [WORD_W-1:0] w_s2;
	logic                     gneg_s2;

	assign g2_sh    = g2_s1[63:16];
	assign g2_sat   = (|g2_sh[47:32]) ? '1 : g2_sh[31:0];
	assign peak_new = norm ? ((g2_sat > dp_s1) ? g2_sat : dp_s1) : peak_s1;
	assign dm_prod  = 64'(dprod_s1) * 64'(cfg.learning_rate);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			peak_s2 <= peak_new;
			dm_s2   <= dm_prod[63:32];
			gl_s2   <= gl_s1;
			w_s2    <= w_s1;
			gneg_s2 <= gneg_s1;
		end
	end

	// decay, then square root of the new peak
	logic signed [WORD_W:0] w_ext, dm_ext, wd;
	root_pay_t              rp_in, rp_out;
	logic                   sq_vld;
	logic [RT_W-1:0]        s_root;

	assign w_ext  = {w_s2[WORD_W-1], w_s2};
	assign dm_ext = {1'b0, dm_s2};
	assign wd     = (upd && dec) ? (w_s2[WORD_W-1] ? (w_ext + dm_ext) : (w_ext - dm_ext))
		: w_ext;
	assign rp_in  = '{gl: gl_s2, wd: wd, gneg: gneg_s2, peak: peak_s2};

	sngu_sqrt #(.XW(SQRT_IN_W), .PW($bits(root_pay_t))) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.x       ({peak_s2, 16'h0000}),
		.pay     (rp_in),
		.out_vld (sq_vld),
		.root    (s_root),
		.out_pay (rp_out)
	);

	// step divide
	logic [WORD_W-1:0] divv;
	logic [WORD_W-1:0] num_hi;
	logic [39:0]       plain_full;
	step_pay_t         sp_in, sp_out;
	logic              d2_vld;
	logic [STEP_W-1:0] quot2;
	logic              ovf;

	assign divv       = {s_root, {DIV2_SHIFT{1'b0}}};
	assign num_hi     = {{(2*WORD_W-STEP_W-WORD_W+STEP_W-29){1'b0}},
		rp_out.gl[2*WORD_W-1:STEP_W]};
	assign ovf        = num_hi >= divv;
	assign plain_full = rp_out.gl[63:24];
	assign sp_in      = '{wd: rp_out.wd, gneg: rp_out.gneg, peak: rp_out.peak, ovf: ovf,
		zero: (s_root == '0),
		plain: (plain_full > 40'(STEP_LIMIT)) ? STEP_LIMIT : plain_full[STEP_W-1:0]};

	sngu_div #(.NW(STEP_W), .DW(WORD_W), .PW($bits(step_pay_t))) u_div_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.rem0    (ovf ? '0 : num_hi),
		.num     (rp_out.gl[STEP_W-1:0]),
		.div     (divv),
		.pay     (sp_in),
		.out_vld (d2_vld),
		.quot    (quot2),
		.out_pay (sp_out)
	);

	// apply step, clip
	logic [STEP_W-1:0]       step_n, step;
	logic signed [SUM_W-1:0] wd_x, step_x, wsum, min_x, max_x;
	logic signed [WORD_W-1:0] w_clip, w_fin;

	assign step_n = sp_out.zero ? '0 : (sp_out.ovf ? STEP_LIMIT
		: ((quot2 > STEP_LIMIT) ? STEP_LIMIT : quot2));
	assign step   = norm ? step_n : sp_out.plain;
	assign wd_x   = {{(SUM_W-WORD_W-1){sp_out.wd[WORD_W]}}, sp_out.wd};
	assign step_x = {1'b0, step};
	assign wsum   = sp_out.gneg ? (wd_x - step_x) : (wd_x + step_x);
	assign min_x  = {{(SUM_W-WORD_W){cfg.min_weight[WORD_W-1]}}, cfg.min_weight};
	assign max_x  = {{(SUM_W-WORD_W){cfg.max_weight[WORD_W-1]}}, cfg.max_weight};
	assign w_clip = (wsum < min_x) ? cfg.min_weight
		: ((wsum > max_x) ? cfg.max_weight : wsum[WORD_W-1:0]);
	assign w_fin  = upd ? w_clip : sp_out.wd[WORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight_out <= w_fin;
			peak_out   <= sp_out.peak;
		end
	end

endmodule

@@ rtl/core/sngu_checker.sv @@
// ----------------------------------------------------------------------------
// sngu_checker
// Port-level checks of the gradient update pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "synapse_normalized_gradient_update_defines.svh"

module sngu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] weight_out,
	input logic [31:0] peak_out,
	input logic        cfg_ready
);

	`SNGU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(weight_out) && $stable(peak_out))
	`SNGU_ASSERT_IMPL(a_ready_follows_out, 1'b1, item_ready == (!result_valid || result_ready))
	`SNGU_ASSERT_IMPL(a_stall_blocks_input, result_valid && !result_ready,
		!item_ready && cfg_ready)
	`SNGU_ASSERT_ALWAYS(a_reset_empty, arst_n || !result_valid)

endmodule

bind synapse_normalized_gradient_update sngu_checker u_sngu_checker (.*);
